FILE: rtl/tfo_pkg.sv
// package: shared types, constants and codes for the tcp flow offset tracker
package tfo_pkg;

	localparam int FLOW_TABLE_DEPTH = 64;
	localparam int ETH_HEADER_BYTES = 14;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'h06;

	localparam int ENTRY_W  = 128;
	localparam int PADDR_W  = 3;
	localparam logic REG_IDX_MAX_FLOWS = 1'b0;

	localparam logic [2:0] ST_NOT_TCP    = 3'd0;
	localparam logic [2:0] ST_TABLE_FULL = 3'd1;
	localparam logic [2:0] ST_NO_PAYLOAD = 3'd2;
	localparam logic [2:0] ST_NEG_OFFSET = 3'd3;
	localparam logic [2:0] ST_PLACED     = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MATCH,
		S_LOOK,
		S_CALC,
		S_UPD,
		S_OUT
	} state_t;

	typedef struct packed {
		logic cap;
		logic cmp;
		logic look;
		logic res_drop;
		logic res_full;
		logic calc;
		logic upd;
	} cmd_t;

	typedef struct packed {
		logic is_tcp;
		logic full;
	} stat_t;

	typedef struct packed {
		logic [15:0] ether_type;
		logic [7:0]  ip_protocol;
		logic [3:0]  ip_header_words;
		logic [15:0] ip_total_length;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [31:0] seq_num;
		logic [31:0] ack_num;
		logic [3:0]  tcp_header_words;
	} pkt_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [6:0]  flow_number;
		logic        reversed;
		logic [30:0] stream_offset;
		logic [15:0] payload_length;
		logic [7:0]  payload_start;
		logic [31:0] stream_length;
		logic [31:0] packet_count;
	} res_t;

	typedef struct packed {
		logic [31:0] packets;
		logic [31:0] extent;
		logic [31:0] base_ack;
		logic [31:0] base_seq;
	} entry_t;

endpackage

FILE: rtl/tfo_pkt_if.sv
// interface: packet header beat channel
interface tfo_pkt_if;
	logic        valid;
	logic        ready;
	logic [15:0] ether_type;
	logic [7:0]  ip_protocol;
	logic [3:0]  ip_header_words;
	logic [15:0] ip_total_length;
	logic [31:0] src_ip;
	logic [31:0] dst_ip;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic [31:0] seq_num;
	logic [31:0] ack_num;
	logic [3:0]  tcp_header_words;

	modport source (
		output valid, ether_type, ip_protocol, ip_header_words, ip_total_length,
		output src_ip, dst_ip, src_port, dst_port, seq_num, ack_num, tcp_header_words,
		input  ready
	);
	modport sink (
		input  valid, ether_type, ip_protocol, ip_header_words, ip_total_length,
		input  src_ip, dst_ip, src_port, dst_port, seq_num, ack_num, tcp_header_words,
		output ready
	);
endinterface

FILE: rtl/tfo_res_if.sv
// interface: result beat channel
interface tfo_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [6:0]  flow_number;
	logic        reversed;
	logic [30:0] stream_offset;
	logic [15:0] payload_length;
	logic [7:0]  payload_start;
	logic [31:0] stream_length;
	logic [31:0] packet_count;

	modport source (
		output valid, status, flow_number, reversed, stream_offset, payload_length,
		output payload_start, stream_length, packet_count,
		input  ready
	);
	modport sink (
		input  valid, status, flow_number, reversed, stream_offset, payload_length,
		input  payload_start, stream_length, packet_count,
		output ready
	);
endinterface

FILE: rtl/tfo_ram.sv
// generic single-write, single-read ram with registered read
module tfo_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/tfo_ctrl.sv
// controller: steps a packet through match, lookup, calculation and update, ending early if not tcp or table full
module tfo_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  tfo_pkg::stat_t stat,
	output tfo_pkg::cmd_t  cmd
);
	tfo_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfo_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tfo_pkg::S_IDLE: begin
				if (in_valid) state_d = tfo_pkg::S_MATCH;
			end
			tfo_pkg::S_MATCH: begin
				state_d = stat.is_tcp ? tfo_pkg::S_LOOK : tfo_pkg::S_OUT;
			end
			tfo_pkg::S_LOOK: begin
				state_d = stat.full ? tfo_pkg::S_OUT : tfo_pkg::S_CALC;
			end
			tfo_pkg::S_CALC: state_d = tfo_pkg::S_UPD;
			tfo_pkg::S_UPD:  state_d = tfo_pkg::S_OUT;
			tfo_pkg::S_OUT: begin
				if (out_ready) state_d = tfo_pkg::S_IDLE;
			end
			default: state_d = tfo_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			tfo_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.cap  = in_valid;
			end
			tfo_pkg::S_MATCH: begin
				cmd.cmp      = stat.is_tcp;
				cmd.res_drop = !stat.is_tcp;
			end
			tfo_pkg::S_LOOK: begin
				cmd.look     = !stat.full;
				cmd.res_full = stat.full;
			end
			tfo_pkg::S_CALC: cmd.calc = 1'b1;
			tfo_pkg::S_UPD:  cmd.upd  = 1'b1;
			tfo_pkg::S_OUT:  out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule

FILE: rtl/tfo_dp.sv
// datapath: endpoint match array, flow count, offset arithmetic and result register
module tfo_dp #(
	parameter int DEPTH     = tfo_pkg::FLOW_TABLE_DEPTH,
	parameter int ETH_BYTES = tfo_pkg::ETH_HEADER_BYTES,
	parameter int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tfo_pkg::cmd_t               cmd,
	output tfo_pkg::stat_t              stat,
	input  tfo_pkg::pkt_t               pkt,
	input  logic [6:0]                  max_flows,
	output logic [IDX_W-1:0]            ram_raddr,
	input  logic [tfo_pkg::ENTRY_W-1:0] ram_rdata,
	output logic                        ram_we,
	output logic [IDX_W-1:0]            ram_waddr,
	output logic [tfo_pkg::ENTRY_W-1:0] ram_wdata,
	output tfo_pkg::res_t               res
);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int MW    = (CNT_W > 7) ? CNT_W : 7;

	tfo_pkg::pkt_t    pkt_q;
	logic [31:0]      a_addr_q [DEPTH];
	logic [15:0]      a_port_q [DEPTH];
	logic [31:0]      b_addr_q [DEPTH];
	logic [15:0]      b_port_q [DEPTH];
	logic [DEPTH-1:0] fwd_q, rev_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] hit_q;
	logic             hrev_q, new_q;
	logic [31:0]      pk_q, bs_q, ba_q, ext_q, off_q;
	logic             haspl_q;
	logic [15:0]      plen_q;
	logic [7:0]       pstart_q;
	tfo_pkg::res_t    res_q;

	logic [IDX_W-1:0] hit_c;
	logic             hrev_c, found_c, cnt_full;
	tfo_pkg::entry_t  rd, wr;
	logic [31:0]      bs0, ba0, ext0, pk0, pk1, bs1, bs2, ba2, off_c;
	logic signed [17:0] dlen;
	logic             has_pl, neg;
	logic [7:0]       pstart_c;
	logic [31:0]      sum_c, ext1;
	logic [IDX_W:0]   hit_inc;

	// capture, parallel endpoint compare
	always_ff @(posedge clk) begin
		if (cmd.cap) pkt_q <= pkt;
		if (cmd.cmp) begin
			for (int i = 0; i < DEPTH; i++) begin
				fwd_q[i] <= (CNT_W'(i) < count_q) &&
					a_addr_q[i] == pkt_q.src_ip && a_port_q[i] == pkt_q.src_port &&
					b_addr_q[i] == pkt_q.dst_ip && b_port_q[i] == pkt_q.dst_port;
				rev_q[i] <= (CNT_W'(i) < count_q) &&
					b_addr_q[i] == pkt_q.src_ip && b_port_q[i] == pkt_q.src_port &&
					a_addr_q[i] == pkt_q.dst_ip && a_port_q[i] == pkt_q.dst_port;
			end
		end
	end

	assign stat.is_tcp = pkt_q.ether_type == tfo_pkg::ETHERTYPE_IPV4 &&
		pkt_q.ip_protocol == tfo_pkg::PROTO_TCP;

	// first match in creation order
	always_comb begin
		hit_c   = count_q[IDX_W-1:0];
		hrev_c  = 1'b0;
		found_c = 1'b0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (fwd_q[i] || rev_q[i]) begin
				hit_c   = IDX_W'(i);
				hrev_c  = !fwd_q[i];
				found_c = 1'b1;
			end
		end
	end

	assign cnt_full = (count_q >= CNT_W'(DEPTH)) ||
		(max_flows != 7'd0 && MW'(count_q) >= MW'(max_flows));
	assign stat.full = !found_c && cnt_full;
	assign ram_raddr = hit_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.look && !found_c) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			hit_q  <= hit_c;
			hrev_q <= hrev_c;
			new_q  <= !found_c;
			if (!found_c) begin
				a_addr_q[hit_c] <= pkt_q.src_ip;
				a_port_q[hit_c] <= pkt_q.src_port;
				b_addr_q[hit_c] <= pkt_q.dst_ip;
				b_port_q[hit_c] <= pkt_q.dst_port;
			end
		end
	end

	// offset calculation
	assign rd   = tfo_pkg::entry_t'(ram_rdata);
	assign bs0  = new_q ? 32'd0 : rd.base_seq;
	assign ba0  = new_q ? 32'd0 : rd.base_ack;
	assign ext0 = new_q ? 32'd0 : rd.extent;
	assign pk0  = new_q ? 32'd0 : rd.packets;
	assign pk1  = (pk0 == 32'hFFFF_FFFF) ? pk0 : pk0 + 32'd1;
	assign bs1  = (pkt_q.seq_num == 32'd0 || pkt_q.ack_num == 32'd0) ? 32'd0 : bs0;

	assign dlen = $signed({2'b00, pkt_q.ip_total_length})
		- $signed({12'd0, pkt_q.ip_header_words, 2'b00})
		- $signed({12'd0, pkt_q.tcp_header_words, 2'b00});
	assign has_pl = dlen > 18'sd0;
	assign pstart_c = 8'(ETH_BYTES) + {2'b00, pkt_q.ip_header_words, 2'b00}
		+ {2'b00, pkt_q.tcp_header_words, 2'b00};

	always_comb begin
		bs2   = bs1;
		ba2   = ba0;
		off_c = 32'd0;
		if (has_pl) begin
			if (bs1 == 32'd0 || ba0 == 32'd0) begin
				bs2 = hrev_q ? pkt_q.ack_num : pkt_q.seq_num;
				ba2 = hrev_q ? pkt_q.seq_num : pkt_q.ack_num;
			end else if (hrev_q) begin
				off_c = (pkt_q.ack_num - bs1) + (pkt_q.seq_num - ba0);
			end else begin
				off_c = (pkt_q.seq_num - bs1) + (pkt_q.ack_num - ba0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			pk_q     <= pk1;
			bs_q     <= bs2;
			ba_q     <= ba2;
			ext_q    <= ext0;
			off_q    <= off_c;
			haspl_q  <= has_pl;
			plen_q   <= dlen[15:0];
			pstart_q <= pstart_c;
		end
	end

	// extent update and write back
	assign neg   = off_q[31];
	assign sum_c = off_q + {16'd0, plen_q};
	assign ext1  = (haspl_q && !neg && sum_c > ext_q) ? sum_c : ext_q;

	assign wr.packets  = pk_q;
	assign wr.extent   = ext1;
	assign wr.base_ack = ba_q;
	assign wr.base_seq = bs_q;
	assign ram_we      = cmd.upd;
	assign ram_waddr   = hit_q;
	assign ram_wdata   = wr;
	assign hit_inc     = {1'b0, hit_q} + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.res_drop) begin
			res_q <= {tfo_pkg::ST_NOT_TCP, 127'd0};
		end else if (cmd.res_full) begin
			res_q <= {tfo_pkg::ST_TABLE_FULL, 127'd0};
		end else if (cmd.upd) begin
			res_q.status <= !haspl_q ? tfo_pkg::ST_NO_PAYLOAD :
				neg ? tfo_pkg::ST_NEG_OFFSET : tfo_pkg::ST_PLACED;
			res_q.flow_number    <= 7'(hit_inc);
			res_q.reversed       <= hrev_q;
			res_q.stream_offset  <= (haspl_q && !neg) ? off_q[30:0] : 31'd0;
			res_q.payload_length <= haspl_q ? plen_q : 16'd0;
			res_q.payload_start  <= pstart_q;
			res_q.stream_length  <= ext1;
			res_q.packet_count   <= pk_q;
		end
	end

	assign res = res_q;
endmodule

FILE: rtl/tcp_flow_offset_tracker_core.sv
// top level: tcp flow offset tracker with apb register port
//
// channel   dir  beat
// pkt_in    in   one frame's ipv4/tcp header fields
// res_out   out  one result per accepted frame
// apb       in   max_flows register at address 0
//
// one frame at a time: a tcp frame passes the match, lookup, calculation and update
// steps before its result is valid, a frame that finds the table full stops after
// lookup and any other frame after match; a new frame waits for the result beat.
// the flow state ram has a registered read, taken in the lookup cycle.
// asynchronous active-low reset clears the flow count, max_flows and the controller.
// a stalled result holds; no new frame is taken until the result beat is taken.
module tcp_flow_offset_tracker_core #(
	parameter int FLOW_TABLE_DEPTH = tfo_pkg::FLOW_TABLE_DEPTH,
	parameter int ETH_HEADER_BYTES = tfo_pkg::ETH_HEADER_BYTES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tfo_pkt_if.sink                     pkt_in,
	tfo_res_if.source                   res_out,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tfo_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	localparam int IDX_W = (FLOW_TABLE_DEPTH > 1) ? $clog2(FLOW_TABLE_DEPTH) : 1;

	logic [6:0]                  max_flows_q;
	tfo_pkg::cmd_t               cmd;
	tfo_pkg::stat_t              stat;
	tfo_pkg::pkt_t               pkt;
	tfo_pkg::res_t               res;
	logic [IDX_W-1:0]            ram_raddr, ram_waddr;
	logic [tfo_pkg::ENTRY_W-1:0] ram_rdata, ram_wdata;
	logic                        ram_we;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_flows_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == tfo_pkg::REG_IDX_MAX_FLOWS) begin
			max_flows_q <= pwdata[6:0];
		end
	end

	assign prdata = (paddr[2] == tfo_pkg::REG_IDX_MAX_FLOWS) ? {25'd0, max_flows_q} : 32'd0;

	assign pkt.ether_type       = pkt_in.ether_type;
	assign pkt.ip_protocol      = pkt_in.ip_protocol;
	assign pkt.ip_header_words  = pkt_in.ip_header_words;
	assign pkt.ip_total_length  = pkt_in.ip_total_length;
	assign pkt.src_ip           = pkt_in.src_ip;
	assign pkt.dst_ip           = pkt_in.dst_ip;
	assign pkt.src_port         = pkt_in.src_port;
	assign pkt.dst_port         = pkt_in.dst_port;
	assign pkt.seq_num          = pkt_in.seq_num;
	assign pkt.ack_num          = pkt_in.ack_num;
	assign pkt.tcp_header_words = pkt_in.tcp_header_words;

	assign res_out.status         = res.status;
	assign res_out.flow_number    = res.flow_number;
	assign res_out.reversed       = res.reversed;
	assign res_out.stream_offset  = res.stream_offset;
	assign res_out.payload_length = res.payload_length;
	assign res_out.payload_start  = res.payload_start;
	assign res_out.stream_length  = res.stream_length;
	assign res_out.packet_count   = res.packet_count;

	tfo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pkt_in.valid),
		.in_ready  (pkt_in.ready),
		.out_valid (res_out.valid),
		.out_ready (res_out.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tfo_dp #(
		.DEPTH     (FLOW_TABLE_DEPTH),
		.ETH_BYTES (ETH_HEADER_BYTES),
		.IDX_W     (IDX_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.pkt       (pkt),
		.max_flows (max_flows_q),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.res       (res)
	);

	tfo_ram #(
		.WIDTH (tfo_pkg::ENTRY_W),
		.DEPTH (FLOW_TABLE_DEPTH),
		.AW    (IDX_W)
	) u_flow_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);
endmodule
